>>> rtl/qpht_pkg.sv
// Package for the quadratic probing hash table: shared types, operation
// and status codes, slot marks and field widths.
// No dependencies.
`default_nettype none

package qpht_pkg;

    // Field widths fixed by the interface
    localparam int KEY_W    = 31;
    localparam int VALUE_W  = 32;
    localparam int MARK_W   = 2;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 3;
    localparam int SIZE_W   = 8;
    localparam int SLOT_W   = 7;
    localparam int COUNT_W  = 8;

    // Bit index of the top key bit, start of the remainder iteration
    localparam logic [4:0] DIV_TOP_BIT = 5'(KEY_W - 1);

    // table_size after reset
    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 8'd128;

    // Request modes (3 acts as a size report)
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SIZE   = 2'd2;

    // Slot marks
    localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
    localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
    localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

    // Response status codes
    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_UPDATED   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_HOME_TOMB = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_REMOVED   = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_SIZE      = 3'd6;

    // One slot of the table as stored in memory
    typedef struct packed {
        logic [MARK_W-1:0]  mark;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIVIDE,
        S_READ,
        S_PROBE,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

>>> rtl/quadratic_probe_hash_table.sv
// Quadratic probing open-addressing key/value table, top level.
// Depends on qpht_pkg and qpht_ram.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   request  | req_valid, req_stall | mode, lookup_key, entry_value
//   response | rsp_valid, rsp_stall | status, live_count, slot_index
//   config   | cfg_wr_en            | cfg_wr_data (table_size)
//
// One request at a time. A size report is accepted, then loads the response
// register. Insert and remove: accept, bit-serial key mod size, then P slot
// reads (P at most the clamped table_size), then respond. After reset a
// clearing pass writes every slot empty with req_stall high. A stalled
// response holds while the next request is taken; that request waits only to
// load its own response.
`default_nettype none

module quadratic_probe_hash_table #(
    parameter int SLOT_DEPTH = 128
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration
    input  wire logic                              cfg_wr_en,
    input  wire logic [qpht_pkg::SIZE_W-1:0]       cfg_wr_data,
    // Request
    input  wire logic                              req_valid,
    output logic                                   req_stall,
    input  wire logic [qpht_pkg::MODE_W-1:0]       mode,
    input  wire logic [qpht_pkg::KEY_W-1:0]        lookup_key,
    input  wire logic signed [qpht_pkg::VALUE_W-1:0] entry_value,
    // Response
    output logic                                   rsp_valid,
    input  wire logic                              rsp_stall,
    output logic [qpht_pkg::STATUS_W-1:0]          status,
    output logic [qpht_pkg::COUNT_W-1:0]           live_count,
    output logic [qpht_pkg::SLOT_W-1:0]            slot_index
);

    localparam int AW = $clog2(SLOT_DEPTH);
    localparam int CW = $clog2(SLOT_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(SLOT_DEPTH - 1);
    localparam int SW = qpht_pkg::SIZE_W;

    // Control state
    qpht_pkg::state_t state_reg, state_next;
    logic [SW-1:0]    table_size_reg, table_size_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    clr_addr_reg, clr_addr_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // Operation payload
    logic [qpht_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic [qpht_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [qpht_pkg::VALUE_W-1:0]  value_reg, value_next;
    logic [SW-1:0]                 n_reg, n_next;
    logic [4:0]                    div_cnt_reg, div_cnt_next;
    logic [SW-1:0]                 rem_reg, rem_next;
    logic [SW-1:0]                 home_reg, home_next;
    logic [SW-1:0]                 idx_reg, idx_next;
    logic [SW-1:0]                 step_reg, step_next;
    logic [SW-1:0]                 p_reg, p_next;
    logic [qpht_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [SW-1:0]                 res_slot_reg, res_slot_next;
    logic [qpht_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [qpht_pkg::COUNT_W-1:0]  live_count_reg, live_count_next;
    logic [qpht_pkg::SLOT_W-1:0]   slot_index_reg, slot_index_next;

    // Memory port
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [AW-1:0]                 ram_raddr;
    logic [qpht_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [qpht_pkg::ENTRY_W-1:0]  ram_rdata;

    // Datapath signals
    logic                          req_fire;
    logic                          rsp_free;
    logic                          is_lookup;
    logic [SW-1:0]                 n_eff;
    logic [SW:0]                   rem_shift;
    logic [SW:0]                   rem_sub;
    logic [SW-1:0]                 rem_step;
    logic [SW:0]                   idx_sum;
    logic [SW:0]                   step_sum;
    logic [SW-1:0]                 idx_adv;
    logic [SW-1:0]                 step_adv;
    logic [SW-1:0]                 p_adv;
    logic                          probe_end;
    qpht_pkg::entry_t              entry_rd;
    qpht_pkg::entry_t              wr_entry;
    logic                          key_hit;
    logic                          finish;
    logic                          probe_wr;
    logic                          cnt_inc;
    logic                          cnt_dec;
    logic [qpht_pkg::STATUS_W-1:0] fin_status;
    logic [SW-1:0]                 fin_slot;

    assign req_fire  = req_valid && !req_stall;
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign is_lookup = (mode == qpht_pkg::MODE_INSERT) || (mode == qpht_pkg::MODE_REMOVE);

    // Clamp table_size into 1 .. SLOT_DEPTH
    always_comb
    begin
        priority if (table_size_reg == '0)
        begin
            n_eff = SW'(1);
        end
        else if (32'(table_size_reg) > 32'(SLOT_DEPTH))
        begin
            n_eff = SW'(SLOT_DEPTH);
        end
        else
        begin
            n_eff = table_size_reg;
        end
    end

    // One restoring remainder step per cycle, key bits MSB first
    assign rem_shift = {rem_reg, key_reg[div_cnt_reg]};
    assign rem_sub   = rem_shift - {1'b0, n_reg};
    assign rem_step  = (rem_shift >= {1'b0, n_reg}) ? rem_sub[SW-1:0] : rem_shift[SW-1:0];

    // Advance the probe: offset p*p grows by 2p+1, kept reduced mod n
    assign idx_sum  = {1'b0, idx_reg} + {1'b0, step_reg};
    assign step_sum = {1'b0, step_reg} + (SW+1)'(2);

    always_comb
    begin
        idx_adv = (idx_sum >= {1'b0, n_reg}) ? SW'(idx_sum - {1'b0, n_reg}) : idx_sum[SW-1:0];
        priority if (n_reg == SW'(1))
        begin
            step_adv = '0;
        end
        else if (step_sum >= {1'b0, n_reg})
        begin
            step_adv = SW'(step_sum - {1'b0, n_reg});
        end
        else
        begin
            step_adv = step_sum[SW-1:0];
        end
    end

    assign p_adv     = p_reg + SW'(1);
    assign probe_end = (p_adv == n_reg) || (idx_adv == home_reg);

    assign entry_rd = qpht_pkg::entry_t'(ram_rdata);
    assign key_hit  = (entry_rd.key == key_reg);

    // Decide the outcome of the slot read this cycle
    always_comb
    begin
        finish     = 1'b0;
        probe_wr   = 1'b0;
        cnt_inc    = 1'b0;
        cnt_dec    = 1'b0;
        wr_entry   = entry_rd;
        fin_status = qpht_pkg::STAT_FULL;
        fin_slot   = '0;
        if (mode_reg == qpht_pkg::MODE_INSERT)
        begin
            priority if (p_reg == '0 && entry_rd.mark == qpht_pkg::MARK_TOMB)
            begin
                finish     = 1'b1;
                fin_status = qpht_pkg::STAT_HOME_TOMB;
            end
            else if (entry_rd.mark != qpht_pkg::MARK_LIVE)
            begin
                finish         = 1'b1;
                probe_wr       = 1'b1;
                cnt_inc        = 1'b1;
                wr_entry.mark  = qpht_pkg::MARK_LIVE;
                wr_entry.key   = key_reg;
                wr_entry.value = value_reg;
                fin_status     = qpht_pkg::STAT_INSERTED;
                fin_slot       = idx_reg;
            end
            else if (key_hit)
            begin
                finish         = 1'b1;
                probe_wr       = 1'b1;
                wr_entry.value = value_reg;
                fin_status     = qpht_pkg::STAT_UPDATED;
                fin_slot       = idx_reg;
            end
            else if (probe_end)
            begin
                finish     = 1'b1;
                fin_status = qpht_pkg::STAT_FULL;
            end
        end
        else
        begin
            priority if (entry_rd.mark == qpht_pkg::MARK_EMPTY)
            begin
                finish     = 1'b1;
                fin_status = qpht_pkg::STAT_NOT_FOUND;
            end
            else if (entry_rd.mark == qpht_pkg::MARK_LIVE && key_hit)
            begin
                finish        = 1'b1;
                probe_wr      = 1'b1;
                cnt_dec       = 1'b1;
                wr_entry.mark = qpht_pkg::MARK_TOMB;
                fin_status    = qpht_pkg::STAT_REMOVED;
                fin_slot      = idx_reg;
            end
            else if (probe_end)
            begin
                finish     = 1'b1;
                fin_status = qpht_pkg::STAT_NOT_FOUND;
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qpht_pkg::S_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = qpht_pkg::S_IDLE;
                end
            end
            qpht_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = is_lookup ? qpht_pkg::S_DIVIDE : qpht_pkg::S_EMIT;
                end
            end
            qpht_pkg::S_DIVIDE:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = qpht_pkg::S_READ;
                end
            end
            qpht_pkg::S_READ:
            begin
                state_next = qpht_pkg::S_PROBE;
            end
            qpht_pkg::S_PROBE:
            begin
                if (finish)
                begin
                    state_next = qpht_pkg::S_EMIT;
                end
            end
            qpht_pkg::S_EMIT:
            begin
                if (rsp_free)
                begin
                    state_next = qpht_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = qpht_pkg::S_IDLE;
            end
        endcase
    end

    // State outputs: request stall and memory port
    always_comb
    begin
        req_stall = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = AW'(idx_reg);
        ram_wdata = wr_entry;
        ram_raddr = AW'(idx_reg);
        unique case (state_reg)
            qpht_pkg::S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            qpht_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
            end
            qpht_pkg::S_PROBE:
            begin
                ram_we    = probe_wr;
                ram_raddr = AW'(idx_adv);
            end
            qpht_pkg::S_DIVIDE,
            qpht_pkg::S_READ,
            qpht_pkg::S_EMIT:
            begin
                req_stall = 1'b1;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // Register next values
    always_comb
    begin
        table_size_next = cfg_wr_en ? cfg_wr_data : table_size_reg;
        count_next      = count_reg;
        clr_addr_next   = clr_addr_reg;
        rsp_valid_next  = rsp_valid_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        n_next          = n_reg;
        div_cnt_next    = div_cnt_reg;
        rem_next        = rem_reg;
        home_next       = home_reg;
        idx_next        = idx_reg;
        step_next       = step_reg;
        p_next          = p_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        status_next     = status_reg;
        live_count_next = live_count_reg;
        slot_index_next = slot_index_reg;

        // Sweep the clearing address
        if (state_reg == qpht_pkg::S_CLEAR)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
        end

        // Capture a request
        if (state_reg == qpht_pkg::S_IDLE && req_fire)
        begin
            mode_next       = mode;
            key_next        = lookup_key;
            value_next      = entry_value;
            n_next          = n_eff;
            div_cnt_next    = qpht_pkg::DIV_TOP_BIT;
            rem_next        = '0;
            res_status_next = qpht_pkg::STAT_SIZE;
            res_slot_next   = '0;
        end

        // Reduce the key, then seed the first probe at home
        if (state_reg == qpht_pkg::S_DIVIDE)
        begin
            rem_next     = rem_step;
            div_cnt_next = div_cnt_reg - 5'd1;
            if (div_cnt_reg == '0)
            begin
                home_next = rem_step;
                idx_next  = rem_step;
                step_next = (n_reg == SW'(1)) ? '0 : SW'(1);
                p_next    = '0;
            end
        end

        // Finish or advance the probe
        if (state_reg == qpht_pkg::S_PROBE)
        begin
            if (finish)
            begin
                res_status_next = fin_status;
                res_slot_next   = fin_slot;
                if (cnt_inc)
                begin
                    count_next = count_reg + CW'(1);
                end
                else if (cnt_dec && count_reg != '0)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            else
            begin
                idx_next  = idx_adv;
                step_next = step_adv;
                p_next    = p_adv;
            end
        end

        // Load the response register, or drop a taken response
        if (state_reg == qpht_pkg::S_EMIT && rsp_free)
        begin
            rsp_valid_next  = 1'b1;
            status_next     = res_status_reg;
            live_count_next = qpht_pkg::COUNT_W'(count_reg);
            slot_index_next = res_slot_reg[qpht_pkg::SLOT_W-1:0];
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= qpht_pkg::S_CLEAR;
            table_size_reg <= qpht_pkg::TABLE_SIZE_RESET;
            count_reg      <= '0;
            clr_addr_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            table_size_reg <= table_size_next;
            count_reg      <= count_next;
            clr_addr_reg   <= clr_addr_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        n_reg          <= n_next;
        div_cnt_reg    <= div_cnt_next;
        rem_reg        <= rem_next;
        home_reg       <= home_next;
        idx_reg        <= idx_next;
        step_reg       <= step_next;
        p_reg          <= p_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        status_reg     <= status_next;
        live_count_reg <= live_count_next;
        slot_index_reg <= slot_index_next;
    end

    assign rsp_valid  = rsp_valid_reg;
    assign status     = status_reg;
    assign live_count = live_count_reg;
    assign slot_index = slot_index_reg;

    // Slot store: mark, key and value in one word
    qpht_ram #(
        .WIDTH (qpht_pkg::ENTRY_W),
        .DEPTH (SLOT_DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

`ifndef SYNTHESIS
    // No slot write while waiting for a request
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qpht_pkg::S_IDLE) |-> !ram_we)
        else $error("slot write while idle");

    // Live count stays within the store
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SLOT_DEPTH))
        else $error("live count above slot depth");

    // Probe slot and probe number stay below the active size
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qpht_pkg::S_PROBE) |-> (idx_reg < n_reg) && (p_reg < n_reg))
        else $error("probe out of range");

    // A response appears only from the respond state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == qpht_pkg::S_EMIT))
        else $error("response loaded outside respond state");
`endif

endmodule

`default_nettype wire

>>> rtl/qpht_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`default_nettype none

module qpht_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire
